@@ sv/assert_macros.svh @@
// assertion helpers used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define CTAP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define CTAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ctap_pkg.sv @@
// ----------------------------------------------------------------------------
// ctap_pkg
// shared types and constants of the cursor to absolute pointer converter
// ----------------------------------------------------------------------------
package ctap_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BOX_X      = 3'd0;
  localparam logic [2:0] REG_BOX_Y      = 3'd1;
  localparam logic [2:0] REG_BOX_W      = 3'd2;
  localparam logic [2:0] REG_BOX_H      = 3'd3;
  localparam logic [2:0] REG_DESKTOP_W  = 3'd4;
  localparam logic [2:0] REG_DESKTOP_H  = 3'd5;

  // divider geometry: 17 quotient bits, one per stage
  localparam int unsigned QBITS   = 17;
  localparam int unsigned NUM_W   = 49;
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned FRONT   = 3;
  localparam int unsigned LANE_ST = FRONT + QBITS;
  localparam int unsigned NSTAGE  = LANE_ST + 1;

  // per axis configuration handed to a lane
  typedef struct packed {
    logic signed [15:0] box;
    logic [14:0]        box_size;
    logic [14:0]        desk_size;
  } axis_cfg_t;

  // divider stage contents
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] d2;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_st_t;

  // what a lane hands to the merge stage
  typedef struct packed {
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_res_t;

endpackage

@@ sv/cursor_to_absolute_pointer_top.sv @@
// ----------------------------------------------------------------------------
// cursor_to_absolute_pointer_top
// cursor position to signed absolute pointer coordinates, two axis lanes
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: cursor_x/y, window_x/y, monitor_x/y, monitor_w/h
// m_axis    out  tdata: pointer_x, pointer_y
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// one beat per cycle while the output is not stalled; 3 front stages,
// 17 divider stages of one quotient bit each, one output register
// each stage holds until the next one frees, so bubbles collapse under stall
// reset clears stage valids and sets the registers to their defaults
// ----------------------------------------------------------------------------
module cursor_to_absolute_pointer_top
  import ctap_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cursor_x, cursor_y, window_x, window_y, monitor_x, monitor_y,
  // monitor_width, monitor_height, zero fill
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pointer_x, pointer_y
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

`include "assert_macros.svh"

  // configuration registers
  axis_cfg_t cfg_x_q, cfg_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= '{box: '0, box_size: 15'd1, desk_size: 15'd1};
      cfg_y_q <= '{box: '0, box_size: 15'd1, desk_size: 15'd1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_X:     cfg_x_q.box       <= cfg_wdata_i;
        REG_BOX_Y:     cfg_y_q.box       <= cfg_wdata_i;
        REG_BOX_W:     cfg_x_q.box_size  <= cfg_wdata_i[14:0];
        REG_BOX_H:     cfg_y_q.box_size  <= cfg_wdata_i[14:0];
        REG_DESKTOP_W: cfg_x_q.desk_size <= cfg_wdata_i[14:0];
        REG_DESKTOP_H: cfg_y_q.desk_size <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic [NSTAGE-1:0] vld_q, en;

  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NSTAGE-1];

  // axis lanes
  lane_res_t res_x, res_y;

  ctap_lane u_lane_x (
    .clk_i    (clk_i),
    .en_i     (en[LANE_ST-1:0]),
    .cfg_i    (cfg_x_q),
    .cursor_i (s_axis_tdata[15:0]),
    .window_i (s_axis_tdata[47:32]),
    .mon_i    (s_axis_tdata[79:64]),
    .msize_i  (s_axis_tdata[110:96]),
    .res_o    (res_x)
  );

  ctap_lane u_lane_y (
    .clk_i    (clk_i),
    .en_i     (en[LANE_ST-1:0]),
    .cfg_i    (cfg_y_q),
    .cursor_i (s_axis_tdata[31:16]),
    .window_i (s_axis_tdata[63:48]),
    .mon_i    (s_axis_tdata[95:80]),
    .msize_i  (s_axis_tdata[125:111]),
    .res_o    (res_y)
  );

  // merge and output register
  ctap_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en[NSTAGE-1]),
    .x_i     (res_x),
    .y_i     (res_y),
    .tdata_o (m_axis_tdata)
  );

  // checks
  `CTAP_ASSERT(a_block_full, clk_i, rst_ni, !s_axis_tready |-> (&vld_q), "input blocked with a free stage")
  `CTAP_ASSERT(a_full_drain, clk_i, rst_ni, ((&vld_q) && m_axis_tready) |-> s_axis_tready, "drain does not free input")
  `CTAP_ASSERT(a_empty_out, clk_i, rst_ni, ($countones(vld_q) == 0) |=> !m_axis_tvalid, "result from empty pipe")

endmodule

@@ sv/ctap_lane.sv @@
// ----------------------------------------------------------------------------
// ctap_lane
// one axis: offset and clamp, products, rounding numerator, pipelined divider
// ----------------------------------------------------------------------------
module ctap_lane
  import ctap_pkg::*;
(
  input  logic                  clk_i,
  input  logic [LANE_ST-1:0]    en_i,
  input  axis_cfg_t             cfg_i,
  input  logic signed [15:0]    cursor_i,
  input  logic signed [15:0]    window_i,
  input  logic signed [15:0]    mon_i,
  input  logic [14:0]           msize_i,
  output lane_res_t             res_o
);

  // stage 1: offset into the letterbox, clamped
  logic signed [17:0] off;
  logic [14:0]        lb, dk;
  logic [14:0]        v_d, v_q, lb_q, dk_q, msz_q;
  logic signed [15:0] m_q;

  always_comb begin
    off = 18'(cursor_i) - 18'(window_i) - 18'(cfg_i.box);
    lb  = (cfg_i.box_size == '0) ? 15'd1 : cfg_i.box_size;
    dk  = (cfg_i.desk_size == '0) ? 15'd1 : cfg_i.desk_size;
    if (off < 0) begin
      v_d = '0;
    end else if (off > $signed({3'b000, lb})) begin
      v_d = lb;
    end else begin
      v_d = off[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v_q   <= v_d;
      lb_q  <= lb;
      dk_q  <= dk;
      m_q   <= mon_i;
      msz_q <= msize_i;
    end
  end

  // stage 2: the three products
  logic signed [31:0] p1_q;
  logic [29:0]        p2_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q  <= 32'(m_q * $signed({1'b0, lb_q}));
      p2_q  <= v_q * msz_q;
      den_q <= lb_q * dk_q;
    end
  end

  // stage 3: scaled numerator, sign split, rounding bias
  logic signed [32:0]    s;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]      mag;
  div_st_t               st_d;
  div_st_t               st_q [QBITS+1];

  always_comb begin
    s   = 33'(p1_q) + $signed({3'b000, p2_q});
    num = ($signed(NUM_W'(s)) <<< 16) - $signed(NUM_W'(s));
    st_d.neg = s[32];
    mag = st_d.neg ? (NUM_W-1)'(-num) : (NUM_W-1)'(num);
    st_d.rem = {mag, 1'b0} + NUM_W'(den_q);
    st_d.d2  = {den_q, 1'b0};
    st_d.ovf = st_d.rem >= {st_d.d2, {QBITS{1'b0}}};
    st_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      st_q[0] <= st_d;
    end
  end

  // divider: one quotient bit per stage, msb first
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    localparam int unsigned B = QBITS - 1 - i;
    logic [NUM_W-1:0] sh;
    div_st_t          nx;
    always_comb begin
      sh = NUM_W'(st_q[i].d2) << B;
      nx = st_q[i];
      if (st_q[i].rem >= sh) begin
        nx.rem    = st_q[i].rem - sh;
        nx.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[FRONT+i]) begin
        st_q[i+1] <= nx;
      end
    end
  end

  assign res_o.quo = st_q[QBITS].quo;
  assign res_o.neg = st_q[QBITS].neg;
  assign res_o.ovf = st_q[QBITS].ovf;

endmodule

@@ sv/ctap_merge.sv @@
// ----------------------------------------------------------------------------
// ctap_merge
// saturates both lane quotients, removes the bias and packs the result beat
// ----------------------------------------------------------------------------
module ctap_merge
  import ctap_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  lane_res_t   x_i,
  input  lane_res_t   y_i,
  output logic [31:0] tdata_o
);

  function automatic logic [15:0] sat(lane_res_t r);
    logic [15:0] o;
    if (r.neg) begin
      o = 16'h8000;
    end else if (r.ovf || r.quo >= QBITS'(65535)) begin
      o = 16'h7fff;
    end else begin
      o = r.quo[15:0] ^ 16'h8000;
    end
    return o;
  endfunction

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tdata_o <= {sat(y_i), sat(x_i)};
    end
  end

endmodule

@@ tb/cursor_to_absolute_pointer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_to_absolute_pointer_checker
// predicts absolute pointer coordinates from input beats and compares them
// with output beats, counting mismatches
// ----------------------------------------------------------------------------
module cursor_to_absolute_pointer_checker
  import ctap_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           seen_o
);

  // pointer_x sits in the low half of the output beat
  typedef struct packed {
    logic signed [15:0] py;
    logic signed [15:0] px;
  } pointer_t;

  // shadow copy of the configuration registers
  logic signed [15:0] lb_x, lb_y;
  logic [14:0]        lb_w, lb_h, desk_w, desk_h;

  pointer_t pointer_q[$];

  assign pending_o = pointer_q.size();

  // one axis of the coordinate conversion, exact rational with round half away
  function automatic logic signed [15:0] axis_coord(
    logic signed [15:0] cur, logic signed [15:0] win, logic signed [15:0] box,
    logic [14:0] box_sz, logic signed [15:0] mon, logic [14:0] mon_sz,
    logic [14:0] desk_sz);
    longint lb, dk, off, num, den, mag, q;
    lb = (box_sz == 0) ? 1 : longint'(box_sz);
    dk = (desk_sz == 0) ? 1 : longint'(desk_sz);
    off = longint'(cur) - longint'(win) - longint'(box);
    if (off < 0) off = 0;
    if (off > lb) off = lb;
    num = (longint'(mon) * lb + off * longint'(mon_sz)) * 65535;
    den = lb * dk;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    q = q - 32768;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pointer_t got, want;
    if (!rst_ni) begin
      lb_x = '0; lb_y = '0; lb_w = 15'd1; lb_h = 15'd1; desk_w = 15'd1; desk_h = 15'd1;
      pointer_q.delete();
      fail_count_o = 0;
      seen_o = 0;
    end else begin
      // output side first: expectations queued this edge need a later beat
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        seen_o++;
        if (pointer_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0d %0d",
                   $time, got.px, got.py);
          fail_count_o++;
        end else begin
          want = pointer_q.pop_front();
          if (got.px !== want.px) begin
            $display("%0t: pointer_x expected %0d actual %0d", $time, want.px, got.px);
            fail_count_o++;
          end
          if (got.py !== want.py) begin
            $display("%0t: pointer_y expected %0d actual %0d", $time, want.py, got.py);
            fail_count_o++;
          end
        end
      end
      // input beat
      if (s_axis_tvalid && s_axis_tready) begin
        want.px = axis_coord(s_axis_tdata[15:0], s_axis_tdata[47:32], lb_x, lb_w,
                             s_axis_tdata[79:64], s_axis_tdata[110:96], desk_w);
        want.py = axis_coord(s_axis_tdata[31:16], s_axis_tdata[63:48], lb_y, lb_h,
                             s_axis_tdata[95:80], s_axis_tdata[125:111], desk_h);
        pointer_q.push_back(want);
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOX_X:     lb_x = cfg_wdata_i;
          REG_BOX_Y:     lb_y = cfg_wdata_i;
          REG_BOX_W:     lb_w = cfg_wdata_i[14:0];
          REG_BOX_H:     lb_h = cfg_wdata_i[14:0];
          REG_DESKTOP_W: desk_w = cfg_wdata_i[14:0];
          REG_DESKTOP_H: desk_h = cfg_wdata_i[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/cursor_to_absolute_pointer_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_to_absolute_pointer_top_test
// drives cursor beats and register settings into the converter with random
// idling on both sides; the checker predicts and compares every output beat
// ----------------------------------------------------------------------------
module cursor_to_absolute_pointer_top_test;
  import ctap_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [31:0]  m_axis_tdata;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_wdata_i = '0;
  int           fail_count, pending, seen;
  bit           steady;
  int           sent;

  always #10 clk_i = ~clk_i;

  cursor_to_absolute_pointer_top uut (.*);

  cursor_to_absolute_pointer_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen));

  // receiver stalls at random except during the steady stretch
  always @(posedge clk_i)
    m_axis_tready <= steady || ($urandom_range(99) >= 14);

  // signed fields that favor edges and the neighborhood of zero
  function automatic logic [15:0] pick_s16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_u15();
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'h7fff;
      2: return 15'($urandom_range(2000));
      default: return 15'($urandom);
    endcase
  endfunction

  // valid stays high after the beat so back to back beats need no gap;
  // idling and drain pull it low
  task automatic send_beat(input logic [15:0] cx, cy, wx, wy, mx, my,
                           input logic [14:0] mw, mh);
    while (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, mh, mw, my, mx, wy, wx, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // random beat, mostly near the letterbox so the clamp does not dominate
  task automatic send_random();
    logic [15:0] wx, wy;
    wx = pick_s16();
    wy = pick_s16();
    if ($urandom_range(3) != 0)
      send_beat(16'(wx + chk.lb_x + $urandom_range(chk.lb_w + 4) - 2),
                16'(wy + chk.lb_y + $urandom_range(chk.lb_h + 4) - 2),
                wx, wy, pick_s16(), pick_s16(), pick_u15(), pick_u15());
    else
      send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic [15:0] bx, by, bw, bh, dw, dh);
    drain();
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_W, bw);
    write_reg(REG_BOX_H, bh);
    write_reg(REG_DESKTOP_W, dw);
    write_reg(REG_DESKTOP_H, dh);
  endtask

  initial begin
    #2000000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    steady = 0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset defaults, extremes of every field
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0, 15'd0);
    send_beat(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
              15'h7fff, 15'h7fff);
    set_all(16'h0000, 16'h0000, 16'd1920, 16'd1080, 16'd3840, 16'd1080);
    // inside the box, left and right of it, zero monitor size, desktop overflow
    send_beat(16'd960, 16'd540, 16'd0, 16'd0, 16'd0, 16'd0, 15'd1920, 15'd1080);
    send_beat(16'hffff, 16'hfff0, 16'd0, 16'd0, 16'd1920, 16'd0, 15'd1920, 15'd1080);
    send_beat(16'd3000, 16'd2000, 16'd0, 16'd0, 16'd1920, 16'd0, 15'd1920, 15'd1080);
    send_beat(16'd100, 16'd100, 16'd0, 16'd0, 16'd500, 16'd500, 15'd0, 15'd0);
    send_beat(16'd1920, 16'd1080, 16'd0, 16'd0, 16'd3000, 16'hfc00, 15'd1920, 15'd1080);
    // rounding: 1/4 of 65535 leaves a fraction of 3/4, with both signs
    set_all(16'h0000, 16'h0000, 16'd2, 16'd2, 16'd2, 16'd2);
    send_beat(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 15'd1, 15'd1);
    send_beat(16'd1, 16'd1, 16'd0, 16'd0, 16'hffff, 16'hffff, 15'd1, 15'd1);
    // extreme registers, including zero sizes and out of range index
    set_all(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000, 16'h7fff);
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hffff);
    send_beat(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
              15'h7fff, 15'h0);
    send_beat(16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'd0, 16'd0, 15'h7fff, 15'h7fff);
    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_beat(16'h7fff, 16'h8000, 16'd0, 16'd0, 16'h8000, 16'h7fff, 15'h7fff, 15'h7fff);

    // random phases with varying settings, a steady stretch in the middle
    for (int ph = 0; ph < 6; ph++) begin
      set_all(pick_s16(), pick_s16(), {1'b0, pick_u15()}, {1'b0, pick_u15()},
              {1'b0, pick_u15()}, {1'b0, pick_u15()});
      steady = (ph == 3);
      for (int n = 0; n < 125; n++) begin
        send_random();
        // hold off until every result has come back
        if (n == 60) drain();
      end
    end
    steady = 0;

    drain();
    $display("covered %0d input beats, %0d output beats over 11 register settings",
             sent, seen);
    $display("directed extremes, clamps, ties and zero sizes, then random phases");
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
